### hw/rtl/rrs6_pkg.sv
// rrs6_pkg: shared constants and types of the six-point spline resampler
// used by rrs6_spline and ring_resampler_spline6_unit; no dependencies
package rrs6_pkg;

   localparam int RING_AW    = 10;
   localparam int RING_DEPTH = 1 << RING_AW;

   localparam int SAMPLE_W  = 16;
   localparam int FRAC_W    = 16;
   localparam int POS_W     = RING_AW + FRAC_W;
   localparam int STEP_W    = 24;
   localparam int THRESH_W  = 28;
   localparam int FILL_W    = 32;
   localparam int CSR_W     = 28;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 1'd1;

   localparam logic [STEP_W-1:0]   STEP_RESET   = 24'd65536;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 28'd67108864;

   localparam int TAP_COUNT = 6;
   localparam int TAP_W     = 3;

   typedef struct packed {
      logic                       vld;
      logic [TAP_W-1:0]           idx;
      logic signed [SAMPLE_W-1:0] data;
   } rrs6_tap_type;

   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] value;
   } rrs6_result_type;

endpackage

### hw/rtl/rrs6_spline.sv
// rrs6_spline: coefficient accumulation and quintic horner evaluation on one
// shared multiplier, followed by a reciprocal-multiply divide by three and saturation
// depends on rrs6_pkg
module rrs6_spline (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rrs6_pkg::FRAC_W-1:0]    frac,
   input  rrs6_pkg::rrs6_tap_type         tap,
   output rrs6_pkg::rrs6_result_type      result
);
   import rrs6_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INIT = 3'd1;
   localparam logic [2:0] S_MLO  = 3'd2;
   localparam logic [2:0] S_MHI  = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_NEXT = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_SAT  = 3'd7;

   localparam int COEF_W      = 26;
   localparam int T_W         = 42;
   localparam int MUL_A_W     = T_W - FRAC_W + 1;
   localparam int MUL_B_W     = FRAC_W + 1;
   localparam int MUL_W       = MUL_A_W + MUL_B_W;
   localparam int PROD_W      = 43;
   localparam int ACC_W       = 60;
   localparam int Q_SHIFT     = 35;
   localparam int Q_W         = 25;
   localparam int DIV_W       = Q_W + 1;
   localparam int RECIP_SHIFT = 27;
   localparam int V_W         = 27;

   localparam logic [2:0] LAST_HSTEP = 3'd4;

   // ceil(2^27 / 3), exact floor for dividends below 2^27
   localparam logic [DIV_W-1:0] RECIP_3 = 26'd44739243;

   localparam logic signed [ACC_W-1:0] RND_STEP = ACC_W'(64'sd32768);
   localparam logic signed [ACC_W-1:0] RND_LAST = ACC_W'(64'sd12 <<< 32);
   localparam logic signed [Q_W:0]     DIV_BIAS = (Q_W+1)'(3 * (1 << 23));
   localparam logic signed [V_W-1:0]   Y_BIAS   = V_W'(1 << 23);
   localparam logic signed [V_W-1:0]   V_MAX    = V_W'(32767);
   localparam logic signed [V_W-1:0]   V_MIN    = -V_W'(32768);

   logic [2:0]                  state_ff, state_in;
   logic [2:0]                  hstep_ff, hstep_in;
   logic signed [COEF_W-1:0]    a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [COEF_W-1:0]    d_ff, d_in, e_ff, e_in;
   logic signed [SAMPLE_W-1:0]  p2_ff, p2_in;
   logic signed [T_W-1:0]       t_ff, t_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic [DIV_W-1:0]            div_ff, div_in, quo_ff, quo_in;
   logic signed [SAMPLE_W-1:0]  res_ff, res_in;
   logic                        done_ff, done_in;

   logic signed [COEF_W-1:0]    pe, da, db, dc, dd, de;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [MUL_W-1:0]     mul_full;
   logic signed [COEF_W-1:0]    x_sel;
   logic signed [Q_W-1:0]       q1;
   logic signed [Q_W:0]         qb;
   logic [2*DIV_W-1:0]          div_prod;
   logic signed [V_W-1:0]       y, v;

   // tap weights of the five polynomial coefficients
   always_comb begin
      pe = COEF_W'(tap.data);
      da = '0;
      db = '0;
      dc = '0;
      dd = '0;
      de = '0;
      unique case (tap.idx)
         3'd0: begin
            da = pe * COEF_W'(2);
            db = -pe;
            dc = pe * -COEF_W'(9);
            dd = pe * COEF_W'(13);
            de = pe * -COEF_W'(5);
         end
         3'd1: begin
            da = pe * -COEF_W'(16);
            db = pe * COEF_W'(16);
            dc = pe * COEF_W'(39);
            dd = pe * -COEF_W'(64);
            de = pe * COEF_W'(25);
         end
         3'd2: begin
            db = pe * -COEF_W'(30);
            dc = pe * -COEF_W'(70);
            dd = pe * COEF_W'(126);
            de = pe * -COEF_W'(50);
         end
         3'd3: begin
            da = pe * COEF_W'(16);
            db = pe * COEF_W'(16);
            dc = pe * COEF_W'(66);
            dd = pe * -COEF_W'(124);
            de = pe * COEF_W'(50);
         end
         3'd4: begin
            da = pe * -COEF_W'(2);
            db = -pe;
            dc = pe * -COEF_W'(33);
            dd = pe * COEF_W'(61);
            de = pe * -COEF_W'(25);
         end
         3'd5: begin
            dc = pe * COEF_W'(7);
            dd = pe * -COEF_W'(12);
            de = pe * COEF_W'(5);
         end
         default: begin
            da = '0;
         end
      endcase
   end

   // shared multiplier: low then high half of t times the fraction
   always_comb begin
      if (state_ff == S_MLO) begin
         mul_a = $signed({{(MUL_A_W-FRAC_W){1'b0}}, t_ff[FRAC_W-1:0]});
      end else begin
         mul_a = MUL_A_W'(t_ff >>> FRAC_W);
      end
      mul_b    = $signed({1'b0, frac});
      mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);
   end

   always_comb begin
      unique case (hstep_ff)
         3'd0:    x_sel = d_ff;
         3'd1:    x_sel = c_ff;
         3'd2:    x_sel = b_ff;
         default: x_sel = a_ff;
      endcase
   end

   always_comb begin
      q1       = Q_W'(acc_ff >>> Q_SHIFT);
      qb       = (Q_W+1)'(q1) + DIV_BIAS;
      div_prod = (2*DIV_W)'(div_ff) * (2*DIV_W)'(RECIP_3);
      y        = $signed(V_W'(quo_ff)) - Y_BIAS;
      v        = V_W'(p2_ff) + y;
   end

   always_comb begin
      state_in = state_ff;
      hstep_in = hstep_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      p2_in    = p2_ff;
      t_in     = t_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (tap.vld) begin
               a_in = (tap.idx == '0 ? '0 : a_ff) + da;
               b_in = (tap.idx == '0 ? '0 : b_ff) + db;
               c_in = (tap.idx == '0 ? '0 : c_ff) + dc;
               d_in = (tap.idx == '0 ? '0 : d_ff) + dd;
               e_in = (tap.idx == '0 ? '0 : e_ff) + de;
               if (tap.idx == 3'd2) begin
                  p2_in = tap.data;
               end
               if (tap.idx == TAP_W'(TAP_COUNT - 1)) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            t_in     = T_W'(e_ff) <<< FRAC_W;
            hstep_in = '0;
            state_in = S_MLO;
         end
         S_MLO: begin
            prod_in  = PROD_W'(mul_full);
            state_in = S_MHI;
         end
         S_MHI: begin
            prod_in  = PROD_W'(mul_full);
            acc_in   = ACC_W'(prod_ff) + (hstep_ff == LAST_HSTEP ? RND_LAST : RND_STEP);
            state_in = S_SUM;
         end
         S_SUM: begin
            acc_in   = acc_ff + (ACC_W'(prod_ff) <<< FRAC_W);
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (hstep_ff == LAST_HSTEP) begin
               div_in   = $unsigned(qb);
               state_in = S_DIV;
            end else begin
               t_in     = (T_W'(x_sel) <<< FRAC_W) + T_W'(acc_ff >>> FRAC_W);
               hstep_in = hstep_ff + 3'd1;
               state_in = S_MLO;
            end
         end
         S_DIV: begin
            quo_in   = DIV_W'(div_prod >> RECIP_SHIFT);
            state_in = S_SAT;
         end
         S_SAT: begin
            priority if (v > V_MAX) begin
               res_in = SAMPLE_W'(V_MAX);
            end else if (v < V_MIN) begin
               res_in = SAMPLE_W'(V_MIN);
            end else begin
               res_in = SAMPLE_W'(v);
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hstep_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hstep_ff <= hstep_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      p2_ff   <= p2_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
   end

   assign result.done  = done_ff;
   assign result.value = res_ff;

endmodule

### hw/rtl/ring_resampler_spline6_unit.sv
// ring_resampler_spline6_unit: one-channel resampler top level with ring
// store, fill and position tracking; depends on rrs6_pkg and rrs6_spline
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    req_kind, req_sample_in
//   rsp      out        rsp_valid/ready    rsp_sample_out, rsp_ready_res
//   csr      in         csr_we             csr_index, csr_wdata
//
// a sample write or a tick before the fill threshold is handled in the idle state
// an interpolating tick runs six ring reads, then five passes of the shared
// multiplier (low half, high half, sum, next), a divide by 3 and saturation
// after reset a pass clears all 1024 ring entries; req_ready stays low meanwhile
// a held result blocks the next transaction only until rsp_ready is seen
module ring_resampler_spline6_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic signed [rrs6_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [rrs6_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic                                   rsp_ready_res,
   input  logic                                   csr_we,
   input  logic [rrs6_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rrs6_pkg::CSR_W-1:0]             csr_wdata
);
   import rrs6_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_CALC  = 2'd3;

   localparam logic KIND_WRITE = 1'b0;

   logic [1:0]                 state_ff, state_in;
   logic [RING_AW-1:0]         clr_ff, clr_in;
   logic [RING_AW-1:0]         wpos_ff, wpos_in;
   logic [POS_W-1:0]           rpos_ff, rpos_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [THRESH_W-1:0]        thr_ff, thr_in;
   logic [TAP_W-1:0]           rcnt_ff, rcnt_in;
   logic                       tap_vld_ff, tap_vld_in;
   logic [TAP_W-1:0]           tap_idx_ff, tap_idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_res_ff, rsp_res_in;

   logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic signed [SAMPLE_W-1:0] mem_rdata_ff;
   logic                       mem_we;
   logic [RING_AW-1:0]         mem_waddr, mem_raddr;
   logic signed [SAMPLE_W-1:0] mem_wdata;

   logic                       req_fire, rsp_fire, fill_ok;
   rrs6_tap_type               tap_bus;
   rrs6_result_type            spl_out;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign fill_ok   = fill_ff >= FILL_W'(thr_ff);
   assign mem_raddr = rpos_ff[POS_W-1:FRAC_W] + RING_AW'(rcnt_ff) - RING_AW'(2);

   assign tap_bus.vld  = tap_vld_ff;
   assign tap_bus.idx  = tap_idx_ff;
   assign tap_bus.data = mem_rdata_ff;

   rrs6_spline u_spline (
      .clock  (clock),
      .reset  (reset),
      .frac   (rpos_ff[FRAC_W-1:0]),
      .tap    (tap_bus),
      .result (spl_out)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      wpos_in       = wpos_ff;
      rpos_in       = rpos_ff;
      fill_in       = fill_ff;
      step_in       = step_ff;
      thr_in        = thr_ff;
      rcnt_in       = rcnt_ff;
      tap_vld_in    = 1'b0;
      tap_idx_in    = rcnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_res_in    = rsp_res_ff;
      mem_we        = 1'b0;
      mem_waddr     = wpos_ff;
      mem_wdata     = req_sample_in;

      if (csr_we) begin
         unique case (csr_index)
            CSR_STEP:   step_in = csr_wdata[STEP_W-1:0];
            CSR_THRESH: thr_in  = csr_wdata[THRESH_W-1:0];
            default:    step_in = step_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + RING_AW'(1);
            if (clr_ff == RING_AW'(RING_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_WRITE) begin
                  mem_we  = 1'b1;
                  wpos_in = wpos_ff + RING_AW'(1);
                  if (fill_ff <= FILL_W'(thr_ff)) begin
                     fill_in = fill_ff + FILL_W'(step_ff);
                  end
               end else if (fill_ok) begin
                  rcnt_in  = '0;
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_sample_in = '0;
                  rsp_res_in    = 1'b0;
               end
            end
         end
         ST_READ: begin
            tap_vld_in = 1'b1;
            rcnt_in    = rcnt_ff + TAP_W'(1);
            if (rcnt_ff == TAP_W'(TAP_COUNT - 1)) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (spl_out.done) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = spl_out.value;
               rsp_res_in    = 1'b1;
               rpos_in       = rpos_ff + POS_W'(step_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wpos_ff      <= '0;
         rpos_ff      <= '0;
         fill_ff      <= '0;
         step_ff      <= STEP_RESET;
         thr_ff       <= THRESH_RESET;
         rcnt_ff      <= '0;
         tap_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wpos_ff      <= wpos_in;
         rpos_ff      <= rpos_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         thr_ff       <= thr_in;
         rcnt_ff      <= rcnt_in;
         tap_vld_ff   <= tap_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_idx_ff    <= tap_idx_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_res_ff    <= rsp_res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= ring_mem[mem_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_ready_res  = rsp_res_ff;

   // interpolator finishes only while a tick is being computed
   assert property (@(posedge clock) disable iff (reset)
      spl_out.done |-> state_ff == ST_CALC)
      else $error("interpolator result outside calc");

   // taps reach the interpolator only right after a ring read
   assert property (@(posedge clock) disable iff (reset)
      tap_vld_ff |-> (state_ff == ST_READ || state_ff == ST_CALC))
      else $error("tap outside read sequence");

   // read position moves only when an interpolated result is delivered
   assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && rpos_ff != $past(rpos_ff)) |-> $past(spl_out.done))
      else $error("read position moved without result");

   // a result never appears while the ring is being cleared
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("transaction result during ring clear");

endmodule

### verif/rrs6_tb_pkg.sv
// rrs6_tb_pkg: request kind codes shared by the resampler checker and the
// testbench top; no dependencies
package rrs6_tb_pkg;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_TICK   = 1'b1
   } req_kind_type;

endpackage

### verif/resampler_checker.sv
// resampler_checker: watches the req, rsp and csr ports of the spline resampler,
// predicts every tick result and compares it; depends on rrs6_pkg, rrs6_tb_pkg
module resampler_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic signed [rrs6_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [rrs6_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                 rsp_ready_res,
   input  logic                                 csr_we,
   input  logic [rrs6_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rrs6_pkg::CSR_W-1:0]           csr_wdata,
   output int                                   error_count,
   output int                                   pending_count,
   output int                                   results_seen,
   output int                                   ready_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import rrs6_pkg::*;
   import rrs6_tb_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       ready_res;
   } tick_result_type;

   localparam longint Q16_ONE    = 65536;
   localparam longint Q16_HALF   = 32768;
   localparam longint SPLINE_DEN = longint'(24) << 32;
   localparam longint SAT_HI     = 32767;
   localparam longint SAT_LO     = -32768;

   logic signed [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
   logic [RING_AW-1:0]         wr_pos;
   logic [POS_W-1:0]           rd_pos;
   logic [FILL_W-1:0]          fill_cnt;
   logic [STEP_W-1:0]          step_val;
   logic [THRESH_W-1:0]        thresh_val;
   tick_result_type            expected_ticks [$];
   int                         err_n     = 0;
   int                         results_n = 0;
   int                         ready_n   = 0;

   function automatic longint floor_div(input longint num, input longint den);
      longint quo;
      quo = num / den;
      if ((num % den) != 0 && num < 0) quo -= 1;
      return quo;
   endfunction

   function automatic longint frac_mul_q16(input longint acc, input longint frac);
      return floor_div(acc * frac + Q16_HALF, Q16_ONE);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] spline_sample();
      longint p [TAP_COUNT];
      longint coef_a, coef_b, coef_c, coef_d, coef_e;
      longint acc, frac, sum;
      int     base;
      base = int'(rd_pos[POS_W-1:FRAC_W]);
      frac = longint'(rd_pos[FRAC_W-1:0]);
      for (int k = 0; k < TAP_COUNT; k++) begin
         p[k] = longint'(ring_copy[(base + k - 2 + RING_DEPTH) % RING_DEPTH]);
      end
      coef_a = 16 * (p[3] - p[1]) + 2 * (p[0] - p[4]);
      coef_b = 16 * (p[3] + p[1]) - p[0] - 30 * p[2] - p[4];
      coef_c = 66 * p[3] - 70 * p[2] - 33 * p[4] + 39 * p[1] + 7 * p[5] - 9 * p[0];
      coef_d = 126 * p[2] - 124 * p[3] + 61 * p[4] - 64 * p[1] - 12 * p[5] + 13 * p[0];
      coef_e = 50 * (p[3] - p[2]) + 25 * (p[1] - p[4]) + 5 * (p[5] - p[0]);
      acc = coef_e * Q16_ONE;
      acc = coef_d * Q16_ONE + frac_mul_q16(acc, frac);
      acc = coef_c * Q16_ONE + frac_mul_q16(acc, frac);
      acc = coef_b * Q16_ONE + frac_mul_q16(acc, frac);
      acc = coef_a * Q16_ONE + frac_mul_q16(acc, frac);
      sum = p[2] + floor_div(acc * frac + SPLINE_DEN / 2, SPLINE_DEN);
      if (sum > SAT_HI) sum = SAT_HI;
      else if (sum < SAT_LO) sum = SAT_LO;
      return SAMPLE_W'(sum);
   endfunction

   always @(posedge clock) begin
      tick_result_type exp_r;
      if (reset) begin
         foreach (ring_copy[i]) ring_copy[i] = '0;
         wr_pos     = '0;
         rd_pos     = '0;
         fill_cnt   = '0;
         step_val   = STEP_RESET;
         thresh_val = THRESH_RESET;
         expected_ticks.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEP:   step_val   = csr_wdata[STEP_W-1:0];
               CSR_THRESH: thresh_val = csr_wdata[THRESH_W-1:0];
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_SAMPLE) begin
               if (fill_cnt <= thresh_val) fill_cnt = fill_cnt + step_val;
               ring_copy[wr_pos] = req_sample_in;
               wr_pos = wr_pos + 1'b1;
            end else if (fill_cnt >= thresh_val) begin
               exp_r.sample_out = spline_sample();
               exp_r.ready_res  = 1'b1;
               expected_ticks.push_back(exp_r);
               rd_pos = rd_pos + step_val;
            end else begin
               exp_r = '0;
               expected_ticks.push_back(exp_r);
            end
         end
         if (rsp_valid && rsp_ready) begin
            results_n++;
            if (rsp_ready_res) ready_n++;
            if (expected_ticks.size() == 0) begin
               err_n++;
               $display("%0t: unexpected result, expected none, actual %0d / %0b",
                        $time, rsp_sample_out, rsp_ready_res);
            end else begin
               exp_r = expected_ticks.pop_front();
               if (rsp_sample_out !== exp_r.sample_out) begin
                  err_n++;
                  $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                           $time, exp_r.sample_out, rsp_sample_out);
               end
               if (rsp_ready_res !== exp_r.ready_res) begin
                  err_n++;
                  $display("%0t: ready_res mismatch, expected %0b, actual %0b",
                           $time, exp_r.ready_res, rsp_ready_res);
               end
            end
         end
      end
      error_count   <= err_n;
      pending_count <= expected_ticks.size();
      results_seen  <= results_n;
      ready_seen    <= ready_n;
   end

endmodule

### verif/testbench.sv
// testbench: drives directed and random sample and tick transactions plus
// register settings into ring_resampler_spline6_unit; depends on rrs6_pkg,
// rrs6_tb_pkg and resampler_checker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rrs6_pkg::*;
   import rrs6_tb_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 48;
   localparam int RANDOM_PHASES = 10;
   localparam int STEP_MAX      = (1 << STEP_W) - 1;
   localparam int THRESH_MAX    = (1 << THRESH_W) - 1;
   localparam int Q16_ONE       = 1 << FRAC_W;

   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] SMP_NEG = 16'shFFFF;
   localparam logic signed [SAMPLE_W-1:0] SMP_ONE = 16'sh0001;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic                       req_kind      = KIND_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_ready_res;
   logic                       csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index     = CSR_STEP;
   logic [CSR_W-1:0]           csr_wdata     = '0;

   int error_count, pending_count, results_seen, ready_seen;
   int items_sent   = 0;
   int settings_n   = 0;
   int quiet_cycles = 0;
   bit no_idle      = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ring_resampler_spline6_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_ready_res  (rsp_ready_res),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   resampler_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_ready_res  (rsp_ready_res),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .results_seen   (results_seen),
      .ready_seen     (ready_seen)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 15))
         0:       return SMP_MAX;
         1:       return SMP_MIN;
         2:       return '0;
         3:       return SMP_NEG;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_txn(input req_kind_type kind, input logic signed [SAMPLE_W-1:0] sample);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_sample_in <= sample;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_W-1:0] step_word,
                             input logic [CSR_W-1:0] thresh_word);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_STEP;
      csr_wdata <= step_word;
      @(posedge clock);
      csr_index <= CSR_THRESH;
      csr_wdata <= thresh_word;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_n++;
   endtask

   initial begin
      logic [CSR_W-1:0] step_word, thresh_word;
      int               step_sel, thresh_sel, n_items;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: tick before the fill threshold
      send_txn(KIND_TICK, SMP_MAX);
      send_txn(KIND_SAMPLE, SMP_MAX);
      send_txn(KIND_TICK, '0);

      // zero threshold, unit step, extreme samples
      set_config(CSR_W'(Q16_ONE), '0);
      send_txn(KIND_SAMPLE, SMP_MAX);
      send_txn(KIND_SAMPLE, SMP_MIN);
      send_txn(KIND_SAMPLE, SMP_MAX);
      send_txn(KIND_SAMPLE, SMP_MIN);
      send_txn(KIND_SAMPLE, '0);
      send_txn(KIND_SAMPLE, SMP_NEG);
      send_txn(KIND_SAMPLE, SMP_ONE);
      repeat (4) send_txn(KIND_TICK, '0);

      // step of 1.5 with out-of-width upper bits
      set_config(28'hF018000, '0);
      repeat (4) send_txn(KIND_TICK, SMP_NEG);

      // zero step holds the position
      set_config('0, '0);
      repeat (2) send_txn(KIND_TICK, '0);

      // largest step and threshold: raised threshold, not ready again
      set_config(CSR_W'(STEP_MAX), CSR_W'(THRESH_MAX));
      repeat (3) send_txn(KIND_SAMPLE, random_sample());
      repeat (2) send_txn(KIND_TICK, '0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         step_sel   = $urandom_range(0, 9);
         thresh_sel = $urandom_range(0, 9);
         if (step_sel < 6) step_word = CSR_W'($urandom_range(16384, 262143));
         else if (step_sel < 8) step_word = CSR_W'($urandom_range(1, STEP_MAX));
         else if (step_sel == 8) step_word = CSR_W'(STEP_MAX);
         else step_word = CSR_W'(1);
         if (thresh_sel < 6) begin
            thresh_word = CSR_W'($urandom_range(0, 40 * 65536));
         end else if (thresh_sel == 6) begin
            thresh_word = '0;
         end else if (thresh_sel == 7) begin
            thresh_word = CSR_W'(THRESH_MAX);
            step_word   = CSR_W'($urandom_range(1 << (STEP_W - 1), STEP_MAX));
         end else begin
            thresh_word = CSR_W'($urandom_range(0, 1 << 22));
         end
         step_word[CSR_W-1:STEP_W] = (CSR_W-STEP_W)'($urandom);
         set_config(step_word, thresh_word);
         no_idle = (ph % 4 == 3);
         n_items = $urandom_range(40, 56);
         for (int i = 0; i < n_items; i++) begin
            if (ph == 2 && i == n_items / 2) drain();
            if (i < 6 || $urandom_range(0, 99) >= 45) send_txn(KIND_SAMPLE, random_sample());
            else send_txn(KIND_TICK, random_sample());
         end
      end
      no_idle = 1'b0;
      drain();

      $display("%0d transactions over %0d register settings", items_sent, settings_n + 1);
      $display("%0d tick results checked, %0d of them interpolated", results_seen, ready_seen);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
